// ===== src/mtm_pkg.sv =====
package mtm_pkg;

    // Angle accumulator: pi = 2^31, carried in 34 bits.
    localparam int ZW = 34;
    // Datapath for rotation: pt*INV_GAIN>>16 fits 31 bits, grows by CORDIC gain.
    localparam int RW = 34;
    // Datapath for vectoring: 32-bit sums with 14 guard bits, plus growth.
    localparam int VW = 50;
    localparam int GUARD = 14;
    localparam int MAX_STEPS = 24;
    localparam logic [29:0] INV_GAIN = 30'd652032874;
    localparam logic signed [ZW-1:0] HALF_PI_Z = 34'sd1073741824;
    localparam logic signed [ZW-1:0] PI_Z = 34'sd2147483648;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } mtm_vec_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_SCALE,
        ST_DONE
    } mtm_state_t;

    // States of the vectoring back end.
    typedef enum logic [2:0] {
        B_IDLE, B_ITER, B_MULHI, B_MULLO, B_SUM, B_OUT
    } back_state_t;

    // Arctangent of 2^-i, pi = 2^31.
    function automatic logic signed [ZW-1:0] atan_z(input logic [4:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0: v = 32'h20000000;
                5'd1: v = 32'h12E4051D;
                5'd2: v = 32'h09FB385B;
                5'd3: v = 32'h051111D4;
                5'd4: v = 32'h028B0D43;
                5'd5: v = 32'h0145D7E1;
                5'd6: v = 32'h00A2F61E;
                5'd7: v = 32'h00517C55;
                5'd8: v = 32'h0028BE53;
                5'd9: v = 32'h00145F2E;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2F9;
                5'd15: v = 32'h0000517C;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A2F;
                5'd19: v = 32'h00000517;
                5'd20: v = 32'h0000028B;
                5'd21: v = 32'h00000145;
                5'd22: v = 32'h000000A2;
                5'd23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            atan_z = {2'b00, v};
        end
    endfunction

endpackage

// ===== src/mtm_front.sv =====
// Front end: resolves each particle into px, py with an iterative rotation
// CORDIC and accumulates the negated components into saturating sums. At
// the end of an event it pushes the finished sums into the queue.
module mtm_front import mtm_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_transverse_momentum,
    input  logic signed [15:0] s_azimuth,
    input  logic               s_last_of_event,
    output logic               q_push,
    output mtm_vec_t           q_data,
    input  logic               q_full
);

    mtm_state_t state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic signed [RW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic last_reg, last_next;
    logic [15:0] pt_reg, pt_next;
    logic signed [ZW-1:0] z_in_reg, z_in_next;
    logic signed [31:0] sx_reg, sx_next, sy_reg, sy_next;

    logic [45:0] prod;
    logic signed [RW-1:0] x0, px, py;
    logic signed [RW-1:0] dx, dy;
    logic signed [33:0] nx, ny;

    // Gain-compensated starting length.
    assign prod = pt_reg * INV_GAIN;
    assign x0 = RW'((prod + 46'd32768) >> 16);
    assign dx = y_reg >>> step_reg;
    assign dy = x_reg >>> step_reg;
    assign px = (x_reg + RW'(1 << (GUARD - 1))) >>> GUARD;
    assign py = (y_reg + RW'(1 << (GUARD - 1))) >>> GUARD;
    assign nx = 34'(sx_reg) - 34'(px);
    assign ny = 34'(sy_reg) - 34'(py);

    function automatic logic signed [31:0] sat(input logic signed [33:0] v);
        if (v > 34'sd2147483647) sat = 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648) sat = 32'sh80000000;
        else sat = v[31:0];
    endfunction

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        last_next = last_reg;
        pt_next = pt_reg;
        z_in_next = z_in_reg;
        sx_next = sx_reg;
        sy_next = sy_reg;
        s_ready = 1'b0;
        q_push = 1'b0;
        q_data.x = sx_reg;
        q_data.y = sy_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    pt_next = s_transverse_momentum;
                    z_in_next = ZW'(s_azimuth) <<< 16;
                    last_next = s_last_of_event;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                y_next = '0;
                step_next = '0;
                if (z_in_reg > HALF_PI_Z) begin
                    x_next = -x0;
                    z_next = z_in_reg - PI_Z;
                end else if (z_in_reg < -HALF_PI_Z) begin
                    x_next = -x0;
                    z_next = z_in_reg + PI_Z;
                end else begin
                    x_next = x0;
                    z_next = z_in_reg;
                end
                state_next = ST_ITER;
            end
            ST_ITER: begin
                if (!z_reg[ZW-1]) begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_z(step_reg);
                end else begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_z(step_reg);
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(CORDIC_STEPS - 1)) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!last_reg) begin
                    sx_next = sat(nx);
                    sy_next = sat(ny);
                    state_next = ST_IDLE;
                end else if (!q_full) begin
                    q_push = 1'b1;
                    q_data.x = sat(nx);
                    q_data.y = sat(ny);
                    sx_next = '0;
                    sy_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sx_reg <= '0;
            sy_reg <= '0;
        end else begin
            state_reg <= state_next;
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
        step_reg <= step_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        last_reg <= last_next;
        pt_reg <= pt_next;
        z_in_reg <= z_in_next;
    end

endmodule

// ===== src/mtm_queue.sv =====
// Two-entry queue of finished event sums between front and back.
module mtm_queue import mtm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  mtm_vec_t push_data,
    output logic     full,
    output logic     nonempty,
    input  logic     pop,
    output mtm_vec_t pop_data
);

    mtm_vec_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full = cnt_reg[1];
    assign nonempty = cnt_reg != 2'd0;
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) mem_reg[wp_reg] <= push_data;
    end

endmodule

// ===== src/mtm_back.sv =====
// Back end: vectoring CORDIC gives length and angle of the event sums,
// then the length is scaled by the inverse gain over two multiply steps.
module mtm_back import mtm_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_nonempty,
    output logic               q_pop,
    input  mtm_vec_t           q_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_missing_x,
    output logic signed [31:0] m_missing_y,
    output logic [31:0]        m_missing_magnitude,
    output logic signed [15:0] m_missing_angle
);

    back_state_t state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic signed [VW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic zero_reg, zero_next;
    mtm_vec_t v_reg, v_next;
    logic [55:0] hi_reg, hi_next;
    logic [53:0] lo_reg, lo_next;
    logic [31:0] mag_reg, mag_next;
    logic [15:0] ang_reg, ang_next;

    logic signed [VW-1:0] dx, dy, vx, vy;
    logic [VW-1:0] ux;
    logic [56:0] m, mr;
    logic signed [ZW-1:0] zr;

    assign dx = y_reg >>> step_reg;
    assign dy = x_reg >>> step_reg;
    assign vx = VW'(q_data.x) <<< GUARD;
    assign vy = VW'(q_data.y) <<< GUARD;
    assign ux = x_reg[VW-1] ? '0 : x_reg;
    assign m = 57'(hi_reg) + 57'(lo_reg >> 24);
    assign mr = (m + 57'(1 << (GUARD + 5))) >> (GUARD + 6);
    assign zr = (z_reg + ZW'(32768)) >>> 16;

    assign m_valid = state_reg == B_OUT;
    assign m_missing_x = v_reg.x;
    assign m_missing_y = v_reg.y;
    assign m_missing_magnitude = mag_reg;
    assign m_missing_angle = ang_reg;

    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        zero_next = zero_reg;
        v_next = v_reg;
        hi_next = hi_reg;
        lo_next = lo_reg;
        mag_next = mag_reg;
        ang_next = ang_reg;
        q_pop = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (q_nonempty) begin
                    q_pop = 1'b1;
                    v_next = q_data;
                    zero_next = (q_data.x == 0) && (q_data.y == 0);
                    step_next = '0;
                    if (q_data.x < 0) begin
                        x_next = -vx;
                        y_next = -vy;
                        z_next = PI_Z;
                    end else begin
                        x_next = vx;
                        y_next = vy;
                        z_next = '0;
                    end
                    state_next = B_ITER;
                end
            end
            B_ITER: begin
                if (!y_reg[VW-1]) begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_z(step_reg);
                end else begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_z(step_reg);
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(CORDIC_STEPS - 1)) state_next = B_MULHI;
            end
            B_MULHI: begin
                hi_next = ux[VW-1:24] * INV_GAIN;
                state_next = B_MULLO;
            end
            B_MULLO: begin
                lo_next = ux[23:0] * INV_GAIN;
                state_next = B_SUM;
            end
            B_SUM: begin
                if (zero_reg) begin
                    mag_next = '0;
                    ang_next = '0;
                end else begin
                    mag_next = (mr > 57'hFFFFFFFF) ? 32'hFFFFFFFF : mr[31:0];
                    ang_next = zr[15:0];
                end
                state_next = B_OUT;
            end
            B_OUT: begin
                if (m_ready) state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
        step_reg <= step_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        zero_reg <= zero_next;
        v_reg <= v_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        mag_reg <= mag_next;
        ang_reg <= ang_next;
    end

endmodule

// ===== src/missing_transverse_momentum_top.sv =====
// Flow: a particle passes the scale, iterate and done states of the rotation CORDIC;
// an event result then passes the queue and the vectoring states iterate, multiply
// high, multiply low, sum and output. The front end takes a new particle only once
// it has finished the last one; the vectoring unit handles one event at a time, which sets the rate of short events.
// Reset: synchronous active-low aresetn clears the sums, queue and state.
module missing_transverse_momentum_top import mtm_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_transverse_momentum,
    input  logic signed [15:0] s_azimuth,
    input  logic               s_last_of_event,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_missing_x,
    output logic signed [31:0] m_missing_y,
    output logic [31:0]        m_missing_magnitude,
    output logic signed [15:0] m_missing_angle
);

    logic q_push, q_full, q_nonempty, q_pop;
    mtm_vec_t q_in, q_out;

    mtm_front #(.CORDIC_STEPS(CORDIC_STEPS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_transverse_momentum,
        .s_azimuth, .s_last_of_event, .q_push, .q_data(q_in), .q_full
    );

    mtm_queue u_queue (
        .aclk, .aresetn, .push(q_push), .push_data(q_in), .full(q_full),
        .nonempty(q_nonempty), .pop(q_pop), .pop_data(q_out)
    );

    mtm_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .aclk, .aresetn, .q_nonempty, .q_pop, .q_data(q_out), .m_valid,
        .m_ready, .m_missing_x, .m_missing_y, .m_missing_magnitude,
        .m_missing_angle
    );

`ifndef SYNTHESIS
    // The queue is never pushed while full.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_full)) else $error("queue overflow");
    // The queue is never popped while empty.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_pop && !q_nonempty)) else $error("queue underflow");
    // A result of two zero sums carries zero magnitude.
    a_zero_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_missing_x == 0 && m_missing_y == 0) |->
        (m_missing_magnitude == 0)) else $error("nonzero magnitude");
`endif

endmodule

// ===== tb/missing_transverse_momentum_top_test.sv =====
`timescale 1ns / 100ps

module missing_transverse_momentum_top_test;
    import mtm_pkg::*;

    localparam int STEPS = 16;
    localparam int TAIL_CYCLES = STEPS + 12;
    localparam int LONG_EVENT_COUNT = 40;

    typedef enum logic [1:0] {
        K_PARTICLE,
        K_DRAIN,
        K_QUIET
    } entry_kind_t;

    typedef struct {
        entry_kind_t kind;
        logic [15:0] pt;
        logic signed [15:0] az;
        logic last;
    } particle_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0] mag;
        logic signed [15:0] ang;
    } event_sum_t;

    // Arctangent of 2^-i with pi = 2^31.
    localparam longint ARCTAN [0:23] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
    };
    localparam longint GAIN_INV = 64'd652032874;
    localparam longint QUARTER_TURN = 64'd1073741824;
    localparam longint HALF_TURN = 64'd2147483648;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [15:0] s_transverse_momentum;
    logic signed [15:0] s_azimuth;
    logic s_last_of_event;
    logic m_valid;
    logic m_ready;
    logic signed [31:0] m_missing_x;
    logic signed [31:0] m_missing_y;
    logic [31:0] m_missing_magnitude;
    logic signed [15:0] m_missing_angle;

    particle_t pending_particles[$];
    event_sum_t expected_events[$];
    longint run_sum_x;
    longint run_sum_y;
    int mismatches;
    int send_gap;
    int recv_stall;
    bit quiet;

    missing_transverse_momentum_top #(.CORDIC_STEPS(STEPS)) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_transverse_momentum(s_transverse_momentum),
        .s_azimuth(s_azimuth),
        .s_last_of_event(s_last_of_event),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_missing_x(m_missing_x),
        .m_missing_y(m_missing_y),
        .m_missing_magnitude(m_missing_magnitude),
        .m_missing_angle(m_missing_angle)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Rotates pt to its azimuth and returns the momentum components in Q0, on the scale of pt.
    function automatic void resolve_momentum(input longint pt, input longint phi,
                                             output longint px, output longint py);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = longint'((longint'(unsigned'(pt)) * GAIN_INV + 32768) >> 16);
        y = 0;
        z = phi * 65536;
        if (z > QUARTER_TURN) begin
            x = -x;
            z = z - HALF_TURN;
        end else if (z < -QUARTER_TURN) begin
            x = -x;
            z = z + HALF_TURN;
        end
        for (int i = 0; i < STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN[i];
            end
        end
        px = (x + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
        py = (y + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
    endfunction

    // Length and direction of the summed vector.
    function automatic void vector_to_polar(input longint vx, input longint vy,
                                            output logic [31:0] mag,
                                            output logic [15:0] ang);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint unsigned ux;
        longint unsigned m;
        x = vx <<< GUARD;
        y = vy <<< GUARD;
        z = 0;
        if (vx == 0 && vy == 0) begin
            mag = '0;
            ang = '0;
            return;
        end
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN[i];
            end
        end
        ux = (x < 0) ? 0 : longint'(x);
        m = (ux >> 24) * GAIN_INV + (((ux & 64'hFFFFFF) * GAIN_INV) >> 24);
        m = (m + (64'd1 << (GUARD + 5))) >> (GUARD + 6);
        if (m > 64'hFFFFFFFF) m = 64'hFFFFFFFF;
        mag = m[31:0];
        ang = 16'(((z + 32768) >>> 16));
    endfunction

    // Folds one accepted particle into the event sums; closes the event on its last one.
    function automatic void accumulate_particle(input particle_t p);
        longint px;
        longint py;
        event_sum_t ev;
        resolve_momentum(longint'(p.pt), longint'(p.az), px, py);
        run_sum_x = clamp32(run_sum_x - px);
        run_sum_y = clamp32(run_sum_y - py);
        if (p.last) begin
            ev.x = 32'(run_sum_x);
            ev.y = 32'(run_sum_y);
            vector_to_polar(run_sum_x, run_sum_y, ev.mag, ev.ang);
            expected_events.push_back(ev);
            run_sum_x = 0;
            run_sum_y = 0;
        end
    endfunction

    function automatic void queue_particle(input logic [15:0] pt, input logic [15:0] az,
                                           input logic last);
        particle_t p;
        p.kind = K_PARTICLE;
        p.pt = pt;
        p.az = az;
        p.last = last;
        pending_particles.push_back(p);
    endfunction

    function automatic void queue_marker(input entry_kind_t kind);
        particle_t p;
        p.kind = kind;
        p.pt = '0;
        p.az = '0;
        p.last = 1'b0;
        pending_particles.push_back(p);
    endfunction

    // Sender: feeds particles from the pending queue, with random gaps between items.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_transverse_momentum <= '0;
            s_azimuth <= '0;
            s_last_of_event <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                accumulate_particle('{K_PARTICLE, s_transverse_momentum, s_azimuth,
                                      s_last_of_event});
            end
            if (pending_particles.size() > 0 && pending_particles[0].kind == K_QUIET) begin
                void'(pending_particles.pop_front());
                quiet = 1'b1;
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_particles.size() == 0) begin
                s_valid <= 1'b0;
            end else if (pending_particles[0].kind == K_DRAIN) begin
                // Hold off until every open event result has come back.
                if (expected_events.size() == 0 && !s_valid) begin
                    void'(pending_particles.pop_front());
                end
                s_valid <= 1'b0;
            end else begin
                s_transverse_momentum <= pending_particles[0].pt;
                s_azimuth <= pending_particles[0].az;
                s_last_of_event <= pending_particles[0].last;
                s_valid <= 1'b1;
                void'(pending_particles.pop_front());
                if (!quiet && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(1, 9);
                end
            end
        end
    end

    // Receiver: random stall bursts and comparison of each event result.
    always @(posedge aclk) begin
        event_sum_t ev;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: x=%0d y=%0d mag=%0d ang=%0d",
                                 m_missing_x, m_missing_y, m_missing_magnitude,
                                 m_missing_angle);
                    end
                end else begin
                    ev = expected_events.pop_front();
                    if (m_missing_x !== ev.x || m_missing_y !== ev.y ||
                        m_missing_magnitude !== ev.mag || m_missing_angle !== ev.ang) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected x=%0d y=%0d mag=%0d ang=%0d",
                                     ev.x, ev.y, ev.mag, ev.ang);
                            $display("          actual   x=%0d y=%0d mag=%0d ang=%0d",
                                     m_missing_x, m_missing_y, m_missing_magnitude,
                                     m_missing_angle);
                        end
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0) begin
                    recv_stall <= $urandom_range(1, 9);
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int n;
        logic [15:0] pt;
        run_sum_x = 0;
        run_sum_y = 0;
        mismatches = 0;
        quiet = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_transverse_momentum = '0;
        s_azimuth = '0;
        s_last_of_event = 1'b0;
        m_ready = 1'b0;

        // Directed: zero momentum, extreme momenta and azimuths, both sides of a right angle.
        queue_particle(16'd0, 16'h1234, 1'b1);
        queue_particle(16'hFFFF, 16'sd0, 1'b1);
        queue_particle(16'hFFFF, 16'sd32767, 1'b1);
        queue_particle(16'hFFFF, -16'sd32768, 1'b1);
        queue_particle(16'hFFFF, 16'sd16384, 1'b1);
        queue_particle(16'hFFFF, -16'sd16384, 1'b1);
        queue_particle(16'h8000, 16'sd16385, 1'b1);
        queue_particle(16'h8000, -16'sd16385, 1'b1);
        queue_particle(16'd1, 16'sd12345, 1'b1);
        // Two opposite particles cancel to a zero vector.
        queue_particle(16'd256, 16'sd0, 1'b0);
        queue_particle(16'd256, -16'sd32768, 1'b1);
        // A multi-particle event and one that points almost exactly at pi.
        queue_particle(16'h7FFF, 16'sd8192, 1'b0);
        queue_particle(16'h4000, -16'sd20000, 1'b0);
        queue_particle(16'hFFFF, 16'sd30000, 1'b1);
        queue_particle(16'hFFFF, 16'sd0, 1'b0);
        queue_particle(16'h0001, 16'sd0, 1'b1);
        queue_marker(K_DRAIN);

        // Random events of one to eight particles.
        n = 0;
        while (n < 550) begin
            int len;
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 5))
                    0: pt = 16'hFFFF;
                    1: pt = 16'(($urandom_range(0, 255)));
                    default: pt = 16'($urandom);
                endcase
                queue_particle(pt, 16'($urandom), k == len - 1);
                n++;
            end
            if (n > 300 && n < 309) queue_marker(K_DRAIN);
        end

        // A long event at full momentum toward pi, with no idling.
        queue_marker(K_DRAIN);
        queue_marker(K_QUIET);
        for (int k = 0; k < LONG_EVENT_COUNT; k++) begin
            queue_particle(16'hFFFF, -16'sd32768, k == LONG_EVENT_COUNT - 1);
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_particles.size() == 0);
        @(posedge aclk);
        while (s_valid || expected_events.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
